FILE: rtl/box_circle_contact_depth_assert.svh
// ----------------------------------------------------------------------------
// Box circle contact depth assertion macros
// Concurrent assertion shorthands used by the contact depth module.
// ----------------------------------------------------------------------------
`ifndef BOX_CIRCLE_CONTACT_DEPTH_ASSERT_SVH
`define BOX_CIRCLE_CONTACT_DEPTH_ASSERT_SVH

`ifndef ASSERT_OFF

`define BCD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define BCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define BCD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define BCD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// Box circle contact depth package
// Widths, codes and sequencer types shared by the block.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int FRACTION_BITS_DEF = 8;

   localparam int POS_W   = 24;
   localparam int SCALE_W = 16;
   localparam int HALF_W  = 23;
   localparam int CTR_W   = 26;
   localparam int EXT_W   = 32;
   localparam int DEPTH_W = 26;
   localparam int DIFF_W  = 27;
   localparam int SUM_W   = 33;
   localparam int CAND_W  = 35;
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = 52;
   localparam int SQ_W    = 34;
   localparam int ACC_W   = 69;
   localparam int CNT_W   = 3;

   localparam logic [CNT_W-1:0] SQ_TERMS = 3'd6;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_TEST     = 1'b1;
   localparam logic KIND_BOX    = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_OX,
      ST_MUL_OY,
      ST_MUL_HW,
      ST_MUL_HH,
      ST_ARRANGE,
      ST_DIFF,
      ST_EDGE,
      ST_TEST,
      ST_SQUARE,
      ST_DECIDE,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      MODE_BOX_BOX,
      MODE_BOX_CIRCLE,
      MODE_CIRCLE_CIRCLE
   } mode_type;

endpackage

FILE: rtl/bcd_if.sv
// ----------------------------------------------------------------------------
// Box circle contact depth channels
// Valid/ready channels for collider beats and contact result beats.
// ----------------------------------------------------------------------------
interface bcd_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   op;
   logic                                   kind;
   logic signed [bcd_pkg::POS_W-1:0]       pos_x;
   logic signed [bcd_pkg::POS_W-1:0]       pos_y;
   logic signed [bcd_pkg::POS_W-1:0]       offset_x;
   logic signed [bcd_pkg::POS_W-1:0]       offset_y;
   logic        [bcd_pkg::SCALE_W-1:0]     scale_x;
   logic        [bcd_pkg::SCALE_W-1:0]     scale_y;
   logic        [bcd_pkg::HALF_W-1:0]      half_width;
   logic        [bcd_pkg::HALF_W-1:0]      half_height;

   modport source (output valid, op, kind, pos_x, pos_y, offset_x, offset_y,
                   scale_x, scale_y, half_width, half_height, input ready);
   modport sink   (input valid, op, kind, pos_x, pos_y, offset_x, offset_y,
                   scale_x, scale_y, half_width, half_height, output ready);
endinterface

interface bcd_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [bcd_pkg::DEPTH_W-1:0]     depth_x;
   logic signed [bcd_pkg::DEPTH_W-1:0]     depth_y;

   modport source (output valid, hit, depth_x, depth_y, input ready);
   modport sink   (input valid, hit, depth_x, depth_y, output ready);
endinterface

FILE: rtl/bcd_mul.sv
// ----------------------------------------------------------------------------
// Box circle contact depth multiplier
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module bcd_mul (
   input  logic                                clock,
   input  logic signed [bcd_pkg::MUL_A_W-1:0]  op_a,
   input  logic        [bcd_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [bcd_pkg::MUL_P_W-1:0]  prod
);

   logic signed [bcd_pkg::MUL_P_W:0]   full;
   logic signed [bcd_pkg::MUL_P_W-1:0] prod_ff;

   assign full = op_a * $signed({1'b0, op_b});

   always_ff @(posedge clock) begin
      prod_ff <= full[bcd_pkg::MUL_P_W-1:0];
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/box_circle_contact_depth.sv
// ----------------------------------------------------------------------------
// Box circle contact depth
// Stores one collider and tests later colliders against it, giving a hit
// flag and signed per-axis penetration depth.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  req_bus   in   op, kind, pos, offset, scale, half extents
//  rsp_bus   out  hit, depth_x, depth_y (one beat per test, none per load)
//
//  A load beat and a test beat both use the one shared multiplier for 4
//  scaling products; a test beat on a box pair or an early miss then ends, and
//  otherwise adds 6 partial squares to compare the squared distance.
//  Reset clears the sequencer and the stored collider to a zero box at the
//  origin. A stalled result holds in the output register; the next beat is
//  taken meanwhile and waits only at its own result.
// ----------------------------------------------------------------------------
`include "box_circle_contact_depth_assert.svh"

module box_circle_contact_depth #(
   parameter int FRACTION_BITS = bcd_pkg::FRACTION_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bcd_req_if.sink    req_bus,
   bcd_rsp_if.source  rsp_bus
);

   localparam int PW = bcd_pkg::MUL_P_W;
   localparam int CW = bcd_pkg::CAND_W;

   function automatic logic signed [bcd_pkg::CTR_W-1:0] sat_center(
      input logic signed [PW:0] v);
      logic [PW-bcd_pkg::CTR_W+1:0] top;
      top = v[PW:bcd_pkg::CTR_W-1];
      if (&top || ~|top) begin
         return v[bcd_pkg::CTR_W-1:0];
      end
      return v[PW] ? {1'b1, {(bcd_pkg::CTR_W-1){1'b0}}}
                   : {1'b0, {(bcd_pkg::CTR_W-1){1'b1}}};
   endfunction

   function automatic logic signed [bcd_pkg::DEPTH_W-1:0] sat_depth(
      input logic signed [CW-1:0] v);
      logic [CW-bcd_pkg::DEPTH_W:0] top;
      top = v[CW-1:bcd_pkg::DEPTH_W-1];
      if (&top || ~|top) begin
         return v[bcd_pkg::DEPTH_W-1:0];
      end
      return v[CW-1] ? {1'b1, {(bcd_pkg::DEPTH_W-1){1'b0}}}
                     : {1'b0, {(bcd_pkg::DEPTH_W-1){1'b1}}};
   endfunction

   function automatic logic signed [CW-1:0] pick(
      input logic signed [CW-1:0] first, input logic signed [CW-1:0] second);
      logic [CW-1:0] mf;
      logic [CW-1:0] ms;
      mf = first[CW-1] ? $unsigned(-first) : $unsigned(first);
      ms = second[CW-1] ? $unsigned(-second) : $unsigned(second);
      return (mf < ms) ? first : second;
   endfunction

   function automatic logic [bcd_pkg::SQ_W-1:0] gap(
      input logic signed [bcd_pkg::DIFF_W-1:0] d,
      input logic [bcd_pkg::EXT_W-1:0]        pe,
      input logic                             circ);
      logic signed [CW-1:0] ds;
      logic signed [CW-1:0] u;
      logic signed [CW-1:0] w;
      logic signed [CW-1:0] g;
      ds = CW'(d);
      u  = ds - $signed({{(CW-bcd_pkg::EXT_W){1'b0}}, pe});
      w  = ds + $signed({{(CW-bcd_pkg::EXT_W){1'b0}}, pe});
      if (circ) begin
         g = ds[CW-1] ? -ds : ds;
      end else if (!u[CW-1] && u != '0) begin
         g = u;
      end else if (w[CW-1]) begin
         g = -w;
      end else begin
         g = '0;
      end
      return g[bcd_pkg::SQ_W-1:0];
   endfunction

   bcd_pkg::state_type state_ff, state_in;
   logic [bcd_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   logic                                  in_op_ff, in_kind_ff;
   logic signed [bcd_pkg::POS_W-1:0]      in_pos_x_ff, in_pos_y_ff;
   logic signed [bcd_pkg::POS_W-1:0]      in_off_x_ff, in_off_y_ff;
   logic        [bcd_pkg::SCALE_W-1:0]    in_scale_x_ff, in_scale_y_ff;
   logic        [bcd_pkg::HALF_W-1:0]     in_hw_ff, in_hh_ff;

   logic signed [bcd_pkg::CTR_W-1:0]      new_cx_ff, new_cy_ff;
   logic        [bcd_pkg::EXT_W-1:0]      new_hw_ff;

   logic                                  st_kind_ff;
   logic signed [bcd_pkg::CTR_W-1:0]      st_cx_ff, st_cy_ff;
   logic        [bcd_pkg::EXT_W-1:0]      st_hw_ff, st_hh_ff;

   bcd_pkg::mode_type                     mode_ff;
   logic signed [bcd_pkg::CTR_W-1:0]      p_x_ff, p_y_ff, q_x_ff, q_y_ff;
   logic        [bcd_pkg::EXT_W-1:0]      pe_x_ff, pe_y_ff, qe_x_ff, qe_y_ff;
   logic signed [bcd_pkg::DIFF_W-1:0]     d_x_ff, d_y_ff;
   logic        [bcd_pkg::SUM_W-1:0]      s_x_ff, s_y_ff;
   logic signed [CW-1:0]                  a_x_ff, b_x_ff, a_y_ff, b_y_ff;
   logic        [bcd_pkg::SQ_W-1:0]       v_x_ff, v_y_ff, r_ff;
   logic signed [bcd_pkg::ACC_W-1:0]      acc_ff;
   logic                                  hit_ff;

   logic                                  rsp_valid_ff, rsp_hit_ff;
   logic signed [bcd_pkg::DEPTH_W-1:0]    rsp_dx_ff, rsp_dy_ff;

   logic signed [bcd_pkg::MUL_A_W-1:0]    mul_a;
   logic        [bcd_pkg::MUL_B_W-1:0]    mul_b;
   logic signed [PW-1:0]                  prod;
   logic signed [PW-1:0]                  prod_floor;
   logic signed [PW:0]                    ctr_sum;
   logic signed [bcd_pkg::POS_W-1:0]      ctr_pos;
   logic        [bcd_pkg::EXT_W-1:0]      ext_val;
   logic        [bcd_pkg::EXT_W-1:0]      hh_now;
   logic        [bcd_pkg::SQ_W-1:0]       sq_val;
   logic        [bcd_pkg::CNT_W-1:0]      term_idx;
   logic signed [bcd_pkg::ACC_W-1:0]      term;
   logic                                  accept, slot_free, bb_hit, early_out;
   logic                                  circ_x;
   logic signed [CW-1:0]                  first_x, second_x, first_y, second_y;

   bcd_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign accept    = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == bcd_pkg::ST_IDLE);

   assign prod_floor = prod >>> FRACTION_BITS;
   assign ctr_pos = (state_ff == bcd_pkg::ST_MUL_OY) ? in_pos_x_ff : in_pos_y_ff;
   assign ctr_sum = $signed({{(PW+1-bcd_pkg::POS_W){ctr_pos[bcd_pkg::POS_W-1]}}, ctr_pos})
                  + $signed({prod_floor[PW-1], prod_floor});
   assign ext_val = (|prod_floor[PW-1:bcd_pkg::EXT_W]) ? '1 : prod_floor[bcd_pkg::EXT_W-1:0];
   assign hh_now  = (in_kind_ff == bcd_pkg::KIND_CIRCLE) ? '0 : ext_val;

   assign sq_val = (cnt_ff[2:1] == 2'd0) ? v_x_ff :
                   (cnt_ff[2:1] == 2'd1) ? v_y_ff : r_ff;
   assign term_idx = cnt_ff - 1'b1;
   assign term = term_idx[0] ? (bcd_pkg::ACC_W'(prod) <<< bcd_pkg::MUL_B_W)
                             : bcd_pkg::ACC_W'(prod);

   assign bb_hit = !a_x_ff[CW-1] && (b_x_ff[CW-1] || b_x_ff == '0)
                && !a_y_ff[CW-1] && (b_y_ff[CW-1] || b_y_ff == '0);
   assign early_out = (v_x_ff > r_ff) || (v_y_ff > r_ff);
   assign circ_x = (mode_ff == bcd_pkg::MODE_CIRCLE_CIRCLE);

   assign first_x  = (mode_ff == bcd_pkg::MODE_BOX_BOX) ? a_x_ff : b_x_ff;
   assign second_x = (mode_ff == bcd_pkg::MODE_BOX_BOX) ? b_x_ff : a_x_ff;
   assign first_y  = (mode_ff == bcd_pkg::MODE_BOX_BOX) ? a_y_ff : b_y_ff;
   assign second_y = (mode_ff == bcd_pkg::MODE_BOX_BOX) ? b_y_ff : a_y_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         bcd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bcd_pkg::ST_MUL_OX;
            end
         end
         bcd_pkg::ST_MUL_OX: begin
            mul_a    = bcd_pkg::MUL_A_W'(in_off_x_ff);
            mul_b    = bcd_pkg::MUL_B_W'(in_scale_x_ff);
            state_in = bcd_pkg::ST_MUL_OY;
         end
         bcd_pkg::ST_MUL_OY: begin
            mul_a    = bcd_pkg::MUL_A_W'(in_off_y_ff);
            mul_b    = bcd_pkg::MUL_B_W'(in_scale_y_ff);
            state_in = bcd_pkg::ST_MUL_HW;
         end
         bcd_pkg::ST_MUL_HW: begin
            mul_a    = $signed({{(bcd_pkg::MUL_A_W-bcd_pkg::HALF_W){1'b0}}, in_hw_ff});
            mul_b    = bcd_pkg::MUL_B_W'(in_scale_x_ff);
            state_in = bcd_pkg::ST_MUL_HH;
         end
         bcd_pkg::ST_MUL_HH: begin
            mul_a    = $signed({{(bcd_pkg::MUL_A_W-bcd_pkg::HALF_W){1'b0}}, in_hh_ff});
            mul_b    = bcd_pkg::MUL_B_W'(in_scale_y_ff);
            state_in = bcd_pkg::ST_ARRANGE;
         end
         bcd_pkg::ST_ARRANGE: begin
            state_in = (in_op_ff == bcd_pkg::OP_LOAD) ? bcd_pkg::ST_IDLE : bcd_pkg::ST_DIFF;
         end
         bcd_pkg::ST_DIFF: begin
            state_in = bcd_pkg::ST_EDGE;
         end
         bcd_pkg::ST_EDGE: begin
            state_in = bcd_pkg::ST_TEST;
         end
         bcd_pkg::ST_TEST: begin
            cnt_in = '0;
            if (mode_ff == bcd_pkg::MODE_BOX_BOX || early_out) begin
               state_in = bcd_pkg::ST_RESULT;
            end else begin
               state_in = bcd_pkg::ST_SQUARE;
            end
         end
         bcd_pkg::ST_SQUARE: begin
            if (cnt_ff < bcd_pkg::SQ_TERMS) begin
               mul_a = $signed({{(bcd_pkg::MUL_A_W-bcd_pkg::SQ_W){1'b0}}, sq_val});
               mul_b = cnt_ff[0] ? sq_val[bcd_pkg::SQ_W-1:bcd_pkg::MUL_B_W]
                                 : sq_val[bcd_pkg::MUL_B_W-1:0];
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = bcd_pkg::ST_DECIDE;
            end
         end
         bcd_pkg::ST_DECIDE: begin
            state_in = bcd_pkg::ST_RESULT;
         end
         bcd_pkg::ST_RESULT: begin
            if (slot_free) begin
               state_in = bcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff      <= req_bus.op;
         in_kind_ff    <= req_bus.kind;
         in_pos_x_ff   <= req_bus.pos_x;
         in_pos_y_ff   <= req_bus.pos_y;
         in_off_x_ff   <= req_bus.offset_x;
         in_off_y_ff   <= req_bus.offset_y;
         in_scale_x_ff <= req_bus.scale_x;
         in_scale_y_ff <= req_bus.scale_y;
         in_hw_ff      <= req_bus.half_width;
         in_hh_ff      <= req_bus.half_height;
      end
      case (state_ff)
         bcd_pkg::ST_MUL_OY: new_cx_ff <= sat_center(ctr_sum);
         bcd_pkg::ST_MUL_HW: new_cy_ff <= sat_center(ctr_sum);
         bcd_pkg::ST_MUL_HH: new_hw_ff <= ext_val;
         bcd_pkg::ST_ARRANGE: begin
            if (st_kind_ff == bcd_pkg::KIND_CIRCLE && in_kind_ff == bcd_pkg::KIND_BOX) begin
               p_x_ff  <= new_cx_ff;
               p_y_ff  <= new_cy_ff;
               pe_x_ff <= new_hw_ff;
               pe_y_ff <= hh_now;
               q_x_ff  <= st_cx_ff;
               q_y_ff  <= st_cy_ff;
               qe_x_ff <= st_hw_ff;
               qe_y_ff <= st_hw_ff;
            end else begin
               p_x_ff  <= st_cx_ff;
               p_y_ff  <= st_cy_ff;
               pe_x_ff <= st_hw_ff;
               pe_y_ff <= (st_kind_ff == bcd_pkg::KIND_CIRCLE) ? st_hw_ff : st_hh_ff;
               q_x_ff  <= new_cx_ff;
               q_y_ff  <= new_cy_ff;
               qe_x_ff <= new_hw_ff;
               qe_y_ff <= (in_kind_ff == bcd_pkg::KIND_CIRCLE) ? new_hw_ff : hh_now;
            end
            if (st_kind_ff == bcd_pkg::KIND_BOX && in_kind_ff == bcd_pkg::KIND_BOX) begin
               mode_ff <= bcd_pkg::MODE_BOX_BOX;
            end else if (st_kind_ff == bcd_pkg::KIND_CIRCLE
                         && in_kind_ff == bcd_pkg::KIND_CIRCLE) begin
               mode_ff <= bcd_pkg::MODE_CIRCLE_CIRCLE;
            end else begin
               mode_ff <= bcd_pkg::MODE_BOX_CIRCLE;
            end
         end
         bcd_pkg::ST_DIFF: begin
            d_x_ff <= bcd_pkg::DIFF_W'(p_x_ff) - bcd_pkg::DIFF_W'(q_x_ff);
            d_y_ff <= bcd_pkg::DIFF_W'(p_y_ff) - bcd_pkg::DIFF_W'(q_y_ff);
            s_x_ff <= {1'b0, pe_x_ff} + {1'b0, qe_x_ff};
            s_y_ff <= {1'b0, pe_y_ff} + {1'b0, qe_y_ff};
         end
         bcd_pkg::ST_EDGE: begin
            a_x_ff <= CW'(d_x_ff) + $signed({{(CW-bcd_pkg::SUM_W){1'b0}}, s_x_ff});
            b_x_ff <= CW'(d_x_ff) - $signed({{(CW-bcd_pkg::SUM_W){1'b0}}, s_x_ff});
            a_y_ff <= CW'(d_y_ff) + $signed({{(CW-bcd_pkg::SUM_W){1'b0}}, s_y_ff});
            b_y_ff <= CW'(d_y_ff) - $signed({{(CW-bcd_pkg::SUM_W){1'b0}}, s_y_ff});
            v_x_ff <= gap(d_x_ff, pe_x_ff, circ_x);
            v_y_ff <= gap(d_y_ff, pe_y_ff, circ_x);
            r_ff   <= circ_x ? bcd_pkg::SQ_W'(s_x_ff) : bcd_pkg::SQ_W'(qe_x_ff);
         end
         bcd_pkg::ST_TEST: begin
            hit_ff <= (mode_ff == bcd_pkg::MODE_BOX_BOX) ? bb_hit : 1'b0;
            acc_ff <= '0;
         end
         bcd_pkg::ST_SQUARE: begin
            if (cnt_ff != '0) begin
               acc_ff <= (term_idx >= 3'd4) ? acc_ff - term : acc_ff + term;
            end
         end
         bcd_pkg::ST_DECIDE: hit_ff <= acc_ff[bcd_pkg::ACC_W-1] || (acc_ff == '0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_kind_ff <= bcd_pkg::KIND_BOX;
         st_cx_ff   <= '0;
         st_cy_ff   <= '0;
         st_hw_ff   <= '0;
         st_hh_ff   <= '0;
      end else if (state_ff == bcd_pkg::ST_ARRANGE && in_op_ff == bcd_pkg::OP_LOAD) begin
         st_kind_ff <= in_kind_ff;
         st_cx_ff   <= new_cx_ff;
         st_cy_ff   <= new_cy_ff;
         st_hw_ff   <= new_hw_ff;
         st_hh_ff   <= hh_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == bcd_pkg::ST_RESULT && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bcd_pkg::ST_RESULT && slot_free) begin
         rsp_hit_ff <= hit_ff;
         rsp_dx_ff  <= hit_ff ? sat_depth(pick(first_x, second_x)) : '0;
         rsp_dy_ff  <= hit_ff ? sat_depth(pick(first_y, second_y)) : '0;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.hit     = rsp_hit_ff;
   assign rsp_bus.depth_x = rsp_dx_ff;
   assign rsp_bus.depth_y = rsp_dy_ff;

   `BCD_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == bcd_pkg::ST_MUL_OX)
   `BCD_ASSERT_IMPLIES(a_cnt_bound, clock, reset, state_ff == bcd_pkg::ST_SQUARE, cnt_ff <= bcd_pkg::SQ_TERMS)
   `BCD_ASSERT_IMPLIES(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_dx_ff == '0 && rsp_dy_ff == '0)
   `BCD_ASSERT_NEXT(a_result_waits, clock, reset, state_ff == bcd_pkg::ST_RESULT && !slot_free, state_ff == bcd_pkg::ST_RESULT)

endmodule
